// ===== rtl/core/dct_repetitive_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the DCT repetitive controller
// Shared property shorthands, sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DCT_REPETITIVE_CONTROLLER_UNIT_DEFINES_SVH
`define DCT_REPETITIVE_CONTROLLER_UNIT_DEFINES_SVH

// condition holds at every sampled edge
`define DRC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("repetitive controller check failed");

// antecedent at one edge implies consequent at the next
`define DRC_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("repetitive controller sequence check failed");

`endif

// ===== rtl/core/dct_rc_pkg.sv =====
// ----------------------------------------------------------------------------
// dct_rc_pkg
// Sizes, register codes, shared structs and the cosine table of the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dct_rc_pkg;

    localparam int TAPS       = 256;
    localparam int TAPS_W     = $clog2(TAPS);
    localparam int HSLOTS     = 8;
    localparam int HS_W       = (HSLOTS > 1) ? $clog2(HSLOTS) : 1;
    localparam int COEF_W     = 18;
    localparam int ACC_W      = COEF_W + 16 + TAPS_W;
    localparam int FIR_SH     = TAPS_W + 13;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_W     = $clog2(CMDQ_DEPTH);

    localparam logic signed [9:0] LAG_MAX = 10'(TAPS);
    localparam logic signed [9:0] LAG_MIN = 10'(-TAPS);

    localparam logic signed [COEF_W:0] COEF_MAX = (COEF_W+1)'((1 << (COEF_W - 1)) - 1);
    localparam logic signed [COEF_W:0] COEF_MIN = (COEF_W+1)'(-(1 << (COEF_W - 1)));

    localparam logic signed [ACC_W-1:0] FIR_OFF = ACC_W'(64'd1 << (FIR_SH - 1));

    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef enum logic [2:0] {
        REG_GAIN,
        REG_ACCUM_MAX,
        REG_ACCUM_MIN,
        REG_DRIVE_MAX,
        REG_DRIVE_MIN,
        REG_LAG_COMP,
        REG_HARMONICS
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] gain;
        logic signed [15:0] accum_max;
        logic signed [15:0] accum_min;
        logic signed [15:0] drive_max;
        logic signed [15:0] drive_min;
        logic signed [9:0]  lag_comp;
        logic [63:0]        harmonics;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0]  reference;
        logic signed [15:0]  feedback;
        logic [TAPS_W-1:0]   slot;
        logic [TAPS_W-1:0]   idx;
        logic [TAPS_W-1:0]   coeff_j;
        logic [TAPS_W-1:0]   coeff_m;
        logic                changed;
        logic                do_coeff;
    } cmd_t;

    typedef logic signed [15:0] cos_rom_t [TAPS];

    // Q1.14 cosine over one period, quarter-wave folded series
    function automatic cos_rom_t cos_rom_build();
        cos_rom_t rom;
        longint   p;
        longint   u;
        longint   x;
        longint   x2;
        longint   t;
        longint   c;
        logic     neg;
        int       m;
        for (m = 0; m < TAPS; m++)
        begin
            p   = (longint'(m) << 16) / TAPS;
            u   = (p <= 32768) ? p : 65536 - p;
            neg = 1'b0;
            if (u > 16384)
            begin
                u   = 32768 - u;
                neg = 1'b1;
            end
            x  = (u * PI_Q30) >> 15;
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - (x2 / 56);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 30);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 12);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 2);
            if (t < 0)
            begin
                t = 0;
            end
            c = (t + 32768) >> 16;
            rom[m] = neg ? 16'(-c) : 16'(c);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = cos_rom_build();

endpackage

// ===== rtl/core/dct_repetitive_controller_unit.sv =====
// ----------------------------------------------------------------------------
// dct_repetitive_controller_unit
// DCT-filter repetitive controller: one drive word per sample word.
//
//   channel  direction  handshake          payload
//   sample   in         push / full        reference, feedback, phase
//   result   out        pop / empty        drive
//   config   in         cfg_valid/ready    cfg_index, cfg_data
//
// A sample that keeps its slot passes through the drive state, which waits
// while the output register is full; a coefficient refresh adds the
// coefficient state (one harmonic per cycle); a slot change adds the fetch,
// sum, MAC and finish states, the FIR taps walked by a single multiply-accumulate.
// After reset a clearing pass zeroes all TAPS store entries; full stays high.
// Up to two samples queue ahead of the engine; one drive word waits in the
// output register while the engine works on the next sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_repetitive_controller_unit
    import dct_rc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] reference,
    input  logic signed [15:0] feedback,
    input  logic [15:0]        phase,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] drive,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    cfg_t cfg_reg;
    cmd_t front_cmd, q_cmd;
    logic accept, q_full, q_empty, q_rd, clearing;

    assign cfg_ready = 1'b1;
    assign full      = q_full || clearing;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= 16'sd0;
            cfg_reg.accum_max <= 16'sh7fff;
            cfg_reg.accum_min <= 16'sh8000;
            cfg_reg.drive_max <= 16'sh7fff;
            cfg_reg.drive_min <= 16'sh8000;
            cfg_reg.lag_comp  <= 10'sd0;
            cfg_reg.harmonics <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN:      cfg_reg.gain      <= cfg_data[15:0];
                REG_ACCUM_MAX: cfg_reg.accum_max <= cfg_data[15:0];
                REG_ACCUM_MIN: cfg_reg.accum_min <= cfg_data[15:0];
                REG_DRIVE_MAX: cfg_reg.drive_max <= cfg_data[15:0];
                REG_DRIVE_MIN: cfg_reg.drive_min <= cfg_data[15:0];
                REG_LAG_COMP:  cfg_reg.lag_comp  <= cfg_data[9:0];
                REG_HARMONICS: cfg_reg.harmonics <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    dct_rc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .reference (reference),
        .feedback  (feedback),
        .phase     (phase),
        .cfg       (cfg_reg),
        .cmd       (front_cmd)
    );

    dct_rc_cmd_fifo u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (front_cmd),
        .rd    (q_rd),
        .rdata (q_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    dct_rc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (q_cmd),
        .cmd_valid (!q_empty),
        .cmd_rd    (q_rd),
        .pop       (pop),
        .clearing  (clearing),
        .empty     (empty),
        .drive     (drive)
    );

endmodule

// ===== rtl/core/dct_rc_front.sv =====
// ----------------------------------------------------------------------------
// dct_rc_front
// Takes samples, finds the slot and step direction, tracks coefficient refresh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_rc_front
    import dct_rc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [15:0] reference,
    input  logic signed [15:0] feedback,
    input  logic [15:0]        phase,
    input  cfg_t               cfg,
    output cmd_t               cmd
);

    localparam logic signed [TAPS_W+1:0] HALF   = (TAPS_W+2)'(TAPS / 2);
    localparam logic signed [TAPS_W+1:0] HALF_N = (TAPS_W+2)'(-(TAPS / 2));

    logic [TAPS_W-1:0]   prev_slot_reg, prev_slot_next;
    logic [TAPS_W-1:0]   cursor_reg, cursor_next;
    logic                busy_reg, busy_next;
    logic signed [9:0]   last_lag_reg, last_lag_next;
    logic [63:0]         last_harm_reg, last_harm_next;
    logic signed [9:0]   lag;
    logic [TAPS_W-1:0]   slot, lag_mod, lag_inc, coeff_j;
    logic signed [TAPS_W+1:0] diff;
    logic                recompute, busy_eff, dir_up;

    always_comb
    begin
        if (cfg.lag_comp > LAG_MAX)
            lag = LAG_MAX;
        else if (cfg.lag_comp < LAG_MIN)
            lag = LAG_MIN;
        else
            lag = cfg.lag_comp;
    end

    assign slot      = phase[15 -: TAPS_W];
    assign recompute = (lag != last_lag_reg) || (cfg.harmonics != last_harm_reg);
    assign busy_eff  = recompute || busy_reg;
    assign coeff_j   = recompute ? '0 : cursor_reg;
    assign lag_mod   = lag[TAPS_W-1:0];
    assign lag_inc   = lag_mod + TAPS_W'(1);
    assign diff      = signed'({2'b00, slot}) - signed'({2'b00, prev_slot_reg});

    always_comb
    begin
        if (diff < HALF_N)
            dir_up = 1'b1;
        else if (diff > HALF)
            dir_up = 1'b0;
        else
            dir_up = (diff > 0);
    end

    always_comb
    begin
        cmd.reference = reference;
        cmd.feedback  = feedback;
        cmd.slot      = slot;
        cmd.idx       = dir_up ? slot - lag_inc : slot + lag_inc;
        cmd.coeff_j   = coeff_j;
        cmd.coeff_m   = coeff_j - lag_mod;
        cmd.changed   = (slot != prev_slot_reg);
        cmd.do_coeff  = busy_eff;
    end

    always_comb
    begin
        prev_slot_next = prev_slot_reg;
        cursor_next    = cursor_reg;
        busy_next      = busy_reg;
        last_lag_next  = last_lag_reg;
        last_harm_next = last_harm_reg;
        if (accept)
        begin
            prev_slot_next = slot;
            last_lag_next  = lag;
            last_harm_next = cfg.harmonics;
            if (busy_eff)
            begin
                cursor_next = coeff_j + TAPS_W'(1);
                busy_next   = (coeff_j != TAPS_W'(TAPS - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_slot_reg <= '0;
            cursor_reg    <= '0;
            busy_reg      <= 1'b0;
            last_lag_reg  <= '0;
            last_harm_reg <= '0;
        end
        else
        begin
            prev_slot_reg <= prev_slot_next;
            cursor_reg    <= cursor_next;
            busy_reg      <= busy_next;
            last_lag_reg  <= last_lag_next;
            last_harm_reg <= last_harm_next;
        end
    end

endmodule

// ===== rtl/core/dct_rc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dct_rc_cmd_fifo
// Short command queue between the sample front end and the filter engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_rc_cmd_fifo
    import dct_rc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wdata,
    input  logic rd,
    output cmd_t rdata,
    output logic full,
    output logic empty
);

    cmd_t              mem [CMDQ_DEPTH];
    logic [CMDQ_W-1:0] wptr_reg, wptr_next;
    logic [CMDQ_W-1:0] rptr_reg, rptr_next;
    logic [CMDQ_W:0]   count_reg, count_next;
    logic              do_wr, do_rd;

    assign full  = (count_reg == (CMDQ_W+1)'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + CMDQ_W'(1) : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + CMDQ_W'(1) : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (CMDQ_W+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (CMDQ_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/dct_rc_back.sv =====
// ----------------------------------------------------------------------------
// dct_rc_back
// Coefficient refresh, error accumulation, shared-MAC FIR and output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_rc_back
    import dct_rc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    input  logic               cmd_valid,
    output logic               cmd_rd,
    input  logic               pop,
    output logic               clearing,
    output logic               empty,
    output logic signed [15:0] drive
);

    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-32768);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COEF,
        S_FETCH,
        S_SUM,
        S_MAC,
        S_FINISH,
        S_DRIVE
    } state_t;

    state_t                     state_reg;
    cmd_t                       cmd_reg;
    logic [TAPS_W-1:0]          clr_reg;
    logic [HS_W-1:0]            hn_reg;
    logic signed [COEF_W:0]     csum_reg;
    logic signed [32:0]         prod_reg;
    logic [TAPS_W-1:0]          head_reg;
    logic [TAPS_W:0]            cnt_reg;
    logic                       rdv_reg, mulv_reg;
    logic signed [COEF_W+15:0]  mul_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [15:0]         held_reg;
    logic                       out_valid_reg;
    logic signed [15:0]         drive_reg;

    logic signed [15:0]         corr_mem  [TAPS];
    logic signed [15:0]         dl_mem    [TAPS];
    logic signed [COEF_W-1:0]   coeff_mem [TAPS];
    logic signed [15:0]         corr_rd, dl_rd;
    logic signed [COEF_W-1:0]   coeff_rd;

    logic [7:0]                 harm;
    logic [15:0]                hm;
    logic signed [COEF_W:0]     csum_next;
    logic signed [COEF_W-1:0]   coef_sat;
    logic                       last_h;
    logic signed [16:0]         err;
    logic signed [32:0]         prod_next;
    logic signed [33:0]         prod_rnd;
    logic signed [21:0]         acc_sum, acc_hi;
    logic signed [15:0]         acc_clamp;
    logic signed [ACC_W-1:0]    fir_rnd;
    logic signed [15:0]         fir_y;
    logic signed [15:0]         drv_hi, drv_clamp;
    logic                       out_free;

    logic                       corr_we, dl_we, coeff_we;
    logic [TAPS_W-1:0]          corr_wa, dl_wa, coeff_wa;
    logic signed [15:0]         corr_wd, dl_wd;
    logic signed [COEF_W-1:0]   coeff_wd;

    assign harm      = cfg.harmonics[{hn_reg, 3'b000} +: 8];
    assign hm        = 16'(harm) * 16'(cmd_reg.coeff_m);
    assign csum_next = csum_reg
                     + ((harm != 8'd0) ? (COEF_W+1)'(COS_ROM[hm[TAPS_W-1:0]]) : '0);
    assign last_h    = (hn_reg == HS_W'(HSLOTS - 1));

    always_comb
    begin
        if (csum_next > COEF_MAX)
            coef_sat = COEF_MAX[COEF_W-1:0];
        else if (csum_next < COEF_MIN)
            coef_sat = COEF_MIN[COEF_W-1:0];
        else
            coef_sat = csum_next[COEF_W-1:0];
    end

    assign err       = 17'(cmd_reg.reference) - 17'(cmd_reg.feedback);
    assign prod_next = 33'(cfg.gain) * 33'(err);
    assign prod_rnd  = (34'(prod_reg) + 34'sd2048) >>> 12;
    assign acc_sum   = 22'(prod_rnd) + 22'(corr_rd);
    assign acc_hi    = (acc_sum > 22'(cfg.accum_max)) ? 22'(cfg.accum_max) : acc_sum;
    assign acc_clamp = (acc_hi < 22'(cfg.accum_min)) ? cfg.accum_min : acc_hi[15:0];

    assign fir_rnd = (acc_reg + FIR_OFF) >>> FIR_SH;

    always_comb
    begin
        if (fir_rnd > Y_MAX)
            fir_y = 16'sh7fff;
        else if (fir_rnd < Y_MIN)
            fir_y = 16'sh8000;
        else
            fir_y = fir_rnd[15:0];
    end

    assign drv_hi    = (held_reg > cfg.drive_max) ? cfg.drive_max : held_reg;
    assign drv_clamp = (drv_hi < cfg.drive_min) ? cfg.drive_min : drv_hi;
    assign out_free  = !out_valid_reg || pop;

    assign cmd_rd   = (state_reg == S_IDLE) && cmd_valid;
    assign clearing = (state_reg == S_CLEAR);
    assign empty    = !out_valid_reg;
    assign drive    = drive_reg;

    always_comb
    begin
        corr_we  = 1'b0;
        corr_wa  = cmd_reg.slot;
        corr_wd  = fir_y;
        dl_we    = 1'b0;
        dl_wa    = head_reg - TAPS_W'(1);
        dl_wd    = acc_clamp;
        coeff_we = 1'b0;
        coeff_wa = cmd_reg.coeff_j;
        coeff_wd = coef_sat;
        case (state_reg)
            S_CLEAR:
            begin
                corr_we  = 1'b1;
                corr_wa  = clr_reg;
                corr_wd  = '0;
                dl_we    = 1'b1;
                dl_wa    = clr_reg;
                dl_wd    = '0;
                coeff_we = 1'b1;
                coeff_wa = clr_reg;
                coeff_wd = '0;
            end
            S_COEF:   coeff_we = last_h;
            S_SUM:    dl_we    = 1'b1;
            S_FINISH: corr_we  = 1'b1;
            default:  corr_we  = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (corr_we)
            corr_mem[corr_wa] <= corr_wd;
        corr_rd <= corr_mem[cmd_reg.idx];
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_wa] <= dl_wd;
        dl_rd <= dl_mem[head_reg + cnt_reg[TAPS_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (coeff_we)
            coeff_mem[coeff_wa] <= coeff_wd;
        coeff_rd <= coeff_mem[cnt_reg[TAPS_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= '0;
            clr_reg       <= '0;
            hn_reg        <= '0;
            csum_reg      <= '0;
            prod_reg      <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            mulv_reg      <= 1'b0;
            mul_reg       <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else
        begin
            if ((state_reg == S_DRIVE) && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + TAPS_W'(1);
                    if (clr_reg == TAPS_W'(TAPS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg  <= cmd;
                        hn_reg   <= '0;
                        csum_reg <= '0;
                        if (cmd.do_coeff)
                            state_reg <= S_COEF;
                        else if (cmd.changed)
                            state_reg <= S_FETCH;
                        else
                            state_reg <= S_DRIVE;
                    end
                end
                S_COEF:
                begin
                    csum_reg <= csum_next;
                    hn_reg   <= hn_reg + HS_W'(1);
                    if (last_h)
                        state_reg <= cmd_reg.changed ? S_FETCH : S_DRIVE;
                end
                S_FETCH:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    head_reg  <= head_reg - TAPS_W'(1);
                    cnt_reg   <= '0;
                    rdv_reg   <= 1'b0;
                    mulv_reg  <= 1'b0;
                    acc_reg   <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (!cnt_reg[TAPS_W])
                        cnt_reg <= cnt_reg + (TAPS_W+1)'(1);
                    rdv_reg  <= !cnt_reg[TAPS_W];
                    mulv_reg <= rdv_reg;
                    if (rdv_reg)
                        mul_reg <= (COEF_W+16)'(coeff_rd) * (COEF_W+16)'(dl_rd);
                    if (mulv_reg)
                        acc_reg <= acc_reg + ACC_W'(mul_reg);
                    if (cnt_reg[TAPS_W] && !rdv_reg && !mulv_reg)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    held_reg  <= fir_y;
                    state_reg <= S_DRIVE;
                end
                S_DRIVE:
                begin
                    if (out_free)
                    begin
                        held_reg  <= drv_clamp;
                        drive_reg <= drv_clamp;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/dct_rc_checker.sv =====
// ----------------------------------------------------------------------------
// dct_rc_checker
// Port-level checks of the repetitive controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dct_repetitive_controller_unit_defines.svh"

module dct_rc_checker
    import dct_rc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] drive,
    input logic               cfg_ready
);

    localparam logic [3:0] MAX_PENDING = 4'(CMDQ_DEPTH + 2);

    logic [3:0] pending_reg;
    logic       in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_acc && !out_acc)
            pending_reg <= pending_reg + 4'd1;
        else if (out_acc && !in_acc)
            pending_reg <= pending_reg - 4'd1;
    end

    `DRC_ASSERT(a_cfg_always_ready, cfg_ready)
    `DRC_IMPLY(a_result_holds, (!empty && !pop), (!empty && $stable(drive)))
    `DRC_ASSERT(a_no_orphan_result, (empty || (pending_reg != 4'd0)))
    `DRC_ASSERT(a_pending_bound, (pending_reg <= MAX_PENDING))

endmodule

bind dct_repetitive_controller_unit dct_rc_checker u_dct_rc_checker (.*);
